// ----- rtl/core/rwrs_pkg.sv -----
// rwrs_pkg: shared types, codes and constants of the read/write request scheduler
// no dependencies
`default_nettype none
package rwrs_pkg;
	localparam int DEFAULT_QUEUE_DEPTH = 16;
	localparam int ID_W   = 16;
	localparam int FILE_W = 8;
	localparam int OFF_W  = 48;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_CANCEL   = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;

	localparam logic [1:0] MODE_READ_PRIO  = 2'd1;
	localparam logic [1:0] MODE_WRITE_PRIO = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // capture input item
		logic scan_rd;    // compare entry idx of read queue
		logic scan_wr;    // compare entry idx of write queue
		logic shift_q;    // move entry idx+1 down to idx in selected queue
		logic append;     // write item at tail of its queue
		logic take_head;  // capture head id of selected queue
		logic sel_wr;     // queue selected for shift/take_head
	} rwrs_cmd_t;
endpackage
`default_nettype wire

// ----- rtl/core/rwrs_datapath.sv -----
// rwrs_datapath: queue storage, item register, entry compare and shifting
// depends on rwrs_pkg
`default_nettype none
module rwrs_datapath
	import rwrs_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
	parameter int IDX_W = $clog2(QUEUE_DEPTH)
) (
	input  wire logic             clk,
	input  wire rwrs_cmd_t        cmd,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [IDX_W:0]   tail,
	input  wire logic [ID_W-1:0]  request_id,
	input  wire logic [FILE_W-1:0] file_id,
	input  wire logic [OFF_W-1:0] block_offset,
	input  wire logic             is_write,
	output logic                  hit_loc,
	output logic                  id_hit,
	output logic [ID_W-1:0]       head_id_q
);
	logic [ID_W-1:0]   rd_ids_q  [QUEUE_DEPTH];
	logic [FILE_W-1:0] rd_files_q[QUEUE_DEPTH];
	logic [OFF_W-1:0]  rd_offs_q [QUEUE_DEPTH];
	logic [ID_W-1:0]   wr_ids_q  [QUEUE_DEPTH];
	logic [FILE_W-1:0] wr_files_q[QUEUE_DEPTH];
	logic [OFF_W-1:0]  wr_offs_q [QUEUE_DEPTH];
	logic [ID_W-1:0]   id_q;
	logic [FILE_W-1:0] file_q;
	logic [OFF_W-1:0]  off_q;
	logic              wr_q;
	logic [IDX_W-1:0]  nxt;

	assign nxt = idx + 1'b1;

	always_comb begin
		hit_loc = 1'b0;
		id_hit  = 1'b0;
		if (cmd.scan_rd) begin
			hit_loc = (rd_files_q[idx] == file_q) && (rd_offs_q[idx] == off_q);
			id_hit  = rd_ids_q[idx] == id_q;
		end else if (cmd.scan_wr) begin
			hit_loc = (wr_files_q[idx] == file_q) && (wr_offs_q[idx] == off_q);
			id_hit  = wr_ids_q[idx] == id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q   <= request_id;
			file_q <= file_id;
			off_q  <= block_offset;
			wr_q   <= is_write;
		end
		if (cmd.take_head) begin
			head_id_q <= cmd.sel_wr ? wr_ids_q[0] : rd_ids_q[0];
		end
		if (cmd.shift_q) begin
			if (cmd.sel_wr) begin
				wr_ids_q[idx]   <= wr_ids_q[nxt];
				wr_files_q[idx] <= wr_files_q[nxt];
				wr_offs_q[idx]  <= wr_offs_q[nxt];
			end else begin
				rd_ids_q[idx]   <= rd_ids_q[nxt];
				rd_files_q[idx] <= rd_files_q[nxt];
				rd_offs_q[idx]  <= rd_offs_q[nxt];
			end
		end
		if (cmd.append) begin
			if (wr_q) begin
				wr_ids_q[tail[IDX_W-1:0]]   <= id_q;
				wr_files_q[tail[IDX_W-1:0]] <= file_q;
				wr_offs_q[tail[IDX_W-1:0]]  <= off_q;
			end else begin
				rd_ids_q[tail[IDX_W-1:0]]   <= id_q;
				rd_files_q[tail[IDX_W-1:0]] <= file_q;
				rd_offs_q[tail[IDX_W-1:0]]  <= off_q;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/rwrs_ctrl.sv -----
// rwrs_ctrl: sequencer for add, cancel and dispatch; owns counts, phase, result
// depends on rwrs_pkg
`default_nettype none
module rwrs_ctrl
	import rwrs_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
	parameter int IDX_W = $clog2(QUEUE_DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       operation,
	input  wire logic             is_write,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_wdata,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            status,
	output logic                  hazard,
	output logic                  served_valid,
	output logic                  served_is_write,
	output rwrs_cmd_t             cmd,
	output logic [IDX_W-1:0]      idx,
	output logic [IDX_W:0]        tail,
	input  wire logic             hit_loc,
	input  wire logic             id_hit
);
	localparam logic [IDX_W:0] DEPTH = (IDX_W+1)'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_HAZ, S_APPEND, S_FIND, S_SHIFT, S_DISP, S_DONE
	} state_t;

	state_t          state_q;
	logic [IDX_W:0]  rd_cnt_q, wr_cnt_q, pos_q, cnt_sel;
	logic [1:0]      mode_q;
	logic            wr_q, phase_q, sel_q;

	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign cnt_sel  = sel_q ? wr_cnt_q : rd_cnt_q;
	assign idx      = pos_q[IDX_W-1:0];
	assign tail     = wr_q ? wr_cnt_q : rd_cnt_q;

	always_comb begin
		cmd = '0;
		cmd.sel_wr = sel_q;
		cmd.load = (state_q == S_IDLE) && in_valid && !in_stall;
		unique case (state_q)
			S_HAZ: begin
				cmd.scan_rd = !sel_q && (pos_q < rd_cnt_q);
				cmd.scan_wr = sel_q && (pos_q < wr_cnt_q);
			end
			S_APPEND: cmd.append = 1'b1;
			S_FIND: begin
				cmd.scan_rd = !sel_q && (pos_q < rd_cnt_q);
				cmd.scan_wr = sel_q && (pos_q < wr_cnt_q);
			end
			S_SHIFT: cmd.shift_q = (pos_q + 1'b1) < cnt_sel;
			S_DISP:  cmd.take_head = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
			phase_q <= 1'b1;
			mode_q <= '0;
			out_valid <= 1'b0;
			pos_q <= '0;
			wr_q <= 1'b0;
			sel_q <= 1'b0;
			status <= '0;
			hazard <= 1'b0;
			served_valid <= 1'b0;
			served_is_write <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						wr_q <= is_write;
						pos_q <= '0;
						hazard <= 1'b0;
						served_valid <= 1'b0;
						served_is_write <= 1'b0;
						unique case (op_t'(operation))
							OP_ADD: begin
								if ((is_write ? wr_cnt_q : rd_cnt_q) >= DEPTH) begin
									status <= ST_FULL;
									out_valid <= 1'b1;
								end else begin
									status <= ST_OK;
									sel_q <= !is_write;
									state_q <= S_HAZ;
								end
							end
							OP_CANCEL: begin
								status <= ST_OK;
								sel_q <= is_write;
								state_q <= S_FIND;
							end
							OP_DISPATCH: begin
								status <= ST_OK;
								if (rd_cnt_q == '0 && wr_cnt_q == '0) begin
									out_valid <= 1'b1;
								end else begin
									sel_q <= (phase_q && wr_cnt_q != '0) || rd_cnt_q == '0;
									state_q <= S_DISP;
								end
							end
							default: begin
								status <= ST_OK;
								out_valid <= 1'b1;
							end
						endcase
					end
				end
				S_HAZ: begin
					// walk the other queue until a match or its end
					if (pos_q >= cnt_sel || hit_loc) begin
						hazard <= pos_q < cnt_sel;
						state_q <= S_APPEND;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_APPEND: begin
					if (wr_q) wr_cnt_q <= wr_cnt_q + 1'b1;
					else rd_cnt_q <= rd_cnt_q + 1'b1;
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FIND: begin
					if (pos_q >= cnt_sel) begin
						status <= ST_NOT_FOUND;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (id_hit) begin
						state_q <= S_SHIFT;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_SHIFT: begin
					// close the gap one entry per cycle
					if (cmd.shift_q) begin
						pos_q <= pos_q + 1'b1;
					end else begin
						if (sel_q) wr_cnt_q <= wr_cnt_q - 1'b1;
						else rd_cnt_q <= rd_cnt_q - 1'b1;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DISP: begin
					served_valid <= 1'b1;
					served_is_write <= sel_q;
					if (sel_q) phase_q <= (mode_q == MODE_WRITE_PRIO);
					else phase_q <= (mode_q != MODE_READ_PRIO);
					state_q <= S_SHIFT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/read_write_request_scheduler.sv -----
// channel | handshake           | payload
// in      | in_valid / in_stall | operation is_write request_id file_id block_offset
// out     | out_valid/ out_stall| status hazard served_valid served_id served_is_write
// cfg     | cfg_we              | cfg_wdata (priority_mode)
// one item at a time; steps from input transfer to result valid: add on a full
// queue: result from idle, else hazard walk of the other queue, then append;
// cancel: search, then one-entry-per-cycle compaction; dispatch with both queues
// empty: result from idle, else head, then shift of the served queue.
// input stays stalled until the result has transferred. reset empties both queues
// with no clearing pass; a stalled result holds and blocks input
// depends on rwrs_pkg, rwrs_ctrl, rwrs_datapath
`default_nettype none
module read_write_request_scheduler
	import rwrs_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        operation,
	input  wire logic              is_write,
	input  wire logic [ID_W-1:0]   request_id,
	input  wire logic [FILE_W-1:0] file_id,
	input  wire logic [OFF_W-1:0]  block_offset,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic                   hazard,
	output logic                   served_valid,
	output logic [ID_W-1:0]        served_id,
	output logic                   served_is_write
);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	rwrs_cmd_t        cmd;
	logic [IDX_W-1:0] idx;
	logic [IDX_W:0]   tail;
	logic             hit_loc, id_hit;
	logic [ID_W-1:0]  head_id_q;

	assign served_id = served_valid ? head_id_q : '0;

	rwrs_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .IDX_W(IDX_W)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .operation, .is_write,
		.cfg_we, .cfg_wdata, .out_valid, .out_stall, .status, .hazard,
		.served_valid, .served_is_write, .cmd, .idx, .tail,
		.hit_loc, .id_hit
	);

	rwrs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .IDX_W(IDX_W)) u_dp (
		.clk, .cmd, .idx, .tail, .request_id, .file_id, .block_offset,
		.is_write, .hit_loc, .id_hit, .head_id_q
	);
endmodule
`default_nettype wire

// ----- rtl/core/rwrs_checker.sv -----
// rwrs_checker: port-level assertions for the scheduler, bound to the top level
// depends on rwrs_pkg
`default_nettype none
module rwrs_checker
	import rwrs_pkg::*;
(
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_stall,
	input wire logic            out_valid,
	input wire logic            out_stall,
	input wire logic [1:0]      status,
	input wire logic            hazard,
	input wire logic            served_valid,
	input wire logic [ID_W-1:0] served_id
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(served_id))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hazard && served_valid)) else $error("hazard on a dispatch");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && served_valid |-> status == ST_OK) else $error("bad dispatch status");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("transfer not followed by busy");
endmodule

bind read_write_request_scheduler rwrs_checker u_rwrs_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .status,
	.hazard, .served_valid, .served_id
);
`default_nettype wire

// ----- test/rwrs_checker.sv -----
// rwrs_scoreboard: watches the input and result channels of the request scheduler,
// keeps its own copy of both queues and compares every result transfer
// depends on rwrs_pkg
`timescale 1ns / 1ps
module rwrs_scoreboard
	import rwrs_pkg::*;
#(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_wdata,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [1:0]        operation,
	input  wire logic              is_write,
	input  wire logic [ID_W-1:0]   request_id,
	input  wire logic [FILE_W-1:0] file_id,
	input  wire logic [OFF_W-1:0]  block_offset,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [1:0]        status,
	input  wire logic              hazard,
	input  wire logic              served_valid,
	input  wire logic [ID_W-1:0]   served_id,
	input  wire logic              served_is_write,
	output int                     errors,
	output int                     pending
);
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [FILE_W-1:0] file;
		logic [OFF_W-1:0]  off;
	} entry_t;

	typedef struct packed {
		status_t         st;
		logic            hz;
		logic            sv;
		logic [ID_W-1:0] sid;
		logic            swr;
	} outcome_t;

	entry_t   rd_q[$];
	entry_t   wr_q[$];
	logic     phase_wr;
	logic [1:0] mode;
	outcome_t expected_q[$];

	function automatic logic conflict(ref entry_t q[$], input entry_t e);
		foreach (q[i])
			if (q[i].file == e.file && q[i].off == e.off)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic outcome_t schedule(input op_t op, input logic wr, input entry_t e);
		outcome_t r;
		int pos;
		r = '0;
		r.st = ST_OK;
		case (op)
			OP_ADD: begin
				if ((wr ? wr_q.size() : rd_q.size()) >= DEPTH) begin
					r.st = ST_FULL;
				end else if (wr) begin
					r.hz = conflict(rd_q, e);
					wr_q.insert(wr_q.size(), e);
				end else begin
					r.hz = conflict(wr_q, e);
					rd_q.insert(rd_q.size(), e);
				end
			end
			OP_CANCEL: begin
				// oldest matching entry only
				pos = -1;
				if (wr) begin
					for (int i = 0; i < wr_q.size(); i++)
						if (pos < 0 && wr_q[i].id == e.id)
							pos = i;
					if (pos >= 0)
						wr_q.delete(pos);
				end else begin
					for (int i = 0; i < rd_q.size(); i++)
						if (pos < 0 && rd_q[i].id == e.id)
							pos = i;
					if (pos >= 0)
						rd_q.delete(pos);
				end
				if (pos < 0)
					r.st = ST_NOT_FOUND;
			end
			OP_DISPATCH: begin
				if (rd_q.size() > 0 || wr_q.size() > 0) begin
					if (phase_wr && wr_q.size() == 0)
						phase_wr = 1'b0;
					else if (!phase_wr && rd_q.size() == 0)
						phase_wr = 1'b1;
					r.sv = 1'b1;
					if (phase_wr) begin
						r.sid = wr_q[0].id;
						wr_q.delete(0);
						r.swr = 1'b1;
						if (mode != MODE_WRITE_PRIO)
							phase_wr = 1'b0;
					end else begin
						r.sid = rd_q[0].id;
						rd_q.delete(0);
						if (mode != MODE_READ_PRIO)
							phase_wr = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_r;
		int nerr;
		if (!arst_n) begin
			rd_q.delete();
			wr_q.delete();
			expected_q.delete();
			phase_wr = 1'b1;
			mode = '0;
			errors <= 0;
			pending <= 0;
		end else begin
			nerr = 0;
			if (cfg_we)
				mode = cfg_wdata;
			if (in_valid && !in_stall)
				expected_q.insert(expected_q.size(), schedule(op_t'(operation), is_write,
					'{request_id, file_id, block_offset}));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing expected");
					nerr++;
				end else begin
					exp_r = expected_q[0];
					expected_q.delete(0);
					if (status !== exp_r.st) begin
						$error("status expected %0d actual %0d", exp_r.st, status);
						nerr++;
					end
					if (hazard !== exp_r.hz) begin
						$error("hazard expected %0d actual %0d", exp_r.hz, hazard);
						nerr++;
					end
					if (served_valid !== exp_r.sv) begin
						$error("served_valid expected %0d actual %0d", exp_r.sv, served_valid);
						nerr++;
					end
					if (served_id !== exp_r.sid) begin
						$error("served_id expected %0h actual %0h", exp_r.sid, served_id);
						nerr++;
					end
					if (served_is_write !== exp_r.swr) begin
						$error("served_is_write expected %0d actual %0d", exp_r.swr,
							served_is_write);
						nerr++;
					end
				end
			end
			errors <= errors + nerr;
			pending <= expected_q.size();
		end
	end
endmodule

// ----- test/tb_top.sv -----
// tb_top: stimulus, clock and reset for the read/write request scheduler
// depends on rwrs_pkg, read_write_request_scheduler and rwrs_scoreboard
`timescale 1ns / 1ps
module tb_top;
	import rwrs_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        operation = OP_NONE;
	logic              is_write = 1'b0;
	logic [ID_W-1:0]   request_id = '0;
	logic [FILE_W-1:0] file_id = '0;
	logic [OFF_W-1:0]  block_offset = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic              hazard;
	logic              served_valid;
	logic [ID_W-1:0]   served_id;
	logic              served_is_write;
	int                errors;
	int                pending;
	bit                stim_done = 1'b0;

	// small pools so cancels hit and hazards occur
	logic [ID_W-1:0]   id_pool[8];
	logic [OFF_W-1:0]  off_pool[4];

	read_write_request_scheduler u_dut (.*);

	rwrs_scoreboard u_chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	// result side stalls a random number of cycles per transfer
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_item(input op_t op, input logic wr, input logic [ID_W-1:0] id,
			input logic [FILE_W-1:0] f, input logic [OFF_W-1:0] off, input bit gaps);
		int n;
		n = gaps ? $urandom_range(0, 15) : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		is_write <= wr;
		request_id <= id;
		file_id <= f;
		block_offset <= off;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_and_config(input logic [1:0] m);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item(input bit gaps);
		int r;
		logic [OFF_W-1:0] off;
		r = $urandom_range(0, 99);
		off = $urandom_range(0, 7) == 0 ? OFF_W'({$urandom, $urandom})
			: off_pool[$urandom_range(0, 3)];
		if (r < 45)
			send_item(OP_ADD, 1'($urandom_range(0, 1)), id_pool[$urandom_range(0, 7)],
				$urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1)), off, gaps);
		else if (r < 60)
			send_item(OP_CANCEL, 1'($urandom_range(0, 1)),
				$urandom_range(0, 4) == 0 ? 16'($urandom) : id_pool[$urandom_range(0, 7)],
				8'($urandom), OFF_W'({$urandom, $urandom}), gaps);
		else if (r < 97)
			send_item(OP_DISPATCH, 1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
				OFF_W'({$urandom, $urandom}), gaps);
		else
			send_item(OP_NONE, 1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
				OFF_W'({$urandom, $urandom}), gaps);
	endtask

	initial begin
		foreach (id_pool[i]) id_pool[i] = 16'($urandom);
		id_pool[0] = '0;
		id_pool[1] = '1;
		foreach (off_pool[i]) off_pool[i] = OFF_W'({$urandom, $urandom});
		off_pool[0] = '0;
		off_pool[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, extremes, hazard, cancel miss and hit, full queue
		send_item(OP_DISPATCH, 1'b0, '0, '0, '0, 1'b0);
		send_item(OP_ADD, 1'b0, '1, '1, '1, 1'b0);
		send_item(OP_ADD, 1'b1, '0, '1, '1, 1'b0);
		send_item(OP_ADD, 1'b1, 16'h1234, 8'h00, '0, 1'b0);
		send_item(OP_CANCEL, 1'b1, 16'h9999, '0, '0, 1'b0);
		send_item(OP_CANCEL, 1'b1, 16'h1234, '0, '0, 1'b0);
		send_item(OP_NONE, 1'b1, '1, '1, '1, 1'b0);
		for (int i = 0; i < 17; i++)
			send_item(OP_ADD, 1'b1, 16'(i), 8'(i), 48'(i), 1'b0);
		for (int i = 0; i < 20; i++)
			send_item(OP_DISPATCH, 1'b0, '0, '0, '0, 1'b0);

		for (int ph = 0; ph < 8; ph++) begin
			drain_and_config(2'(ph));
			for (int k = 0; k < 200; k++)
				random_item(ph % 2 == 0 || k < 100);
		end
		in_valid <= 1'b0;
		stim_done <= 1'b1;
	end

	initial begin
		@(posedge stim_done);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/core/rwrs_pkg.sv
rtl/core/rwrs_datapath.sv
rtl/core/rwrs_ctrl.sv
rtl/core/read_write_request_scheduler.sv
rtl/core/rwrs_checker.sv
test/rwrs_checker.sv
test/tb_top.sv
